[hdl/off_pkg.sv]
// Package for the octal field formatter.
// Holds sizes, configuration register indexes and character codes.
// No dependencies.
package off_pkg;

	localparam int MAX_DIGITS = 22;
	localparam int MAX_FIELD  = 64;

	localparam int VALUE_W   = 64;
	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 7;
	localparam int LEN_W     = 7;
	localparam int DCNT_W    = $clog2(MAX_DIGITS + 1);
	localparam int SHIFT_W   = 3 * MAX_DIGITS;

	localparam logic [CFG_IDX_W-1:0] CFG_ALT_FORM     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_JUSTIFY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_FLAGS    = 3'd5;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [LEN_W-1:0] FIELD_MAX = LEN_W'(MAX_FIELD);

endpackage

[hdl/octal_field_formatter.sv]
// Top level of the octal field formatter.
// Depends on off_pkg for sizes, register indexes and character codes.
//
// Usage: a 64-bit unsigned value enters on the s_axis channel, and its
// printf-style octal text leaves on the m_axis channel, one ASCII character
// per transaction, with tlast on the final character and tuser carrying the
// error flag on every character. Formatting options are written through the
// cfg channel, which is always ready; write it only while the block is idle.
// Timing: after an input transaction the value is shifted by one octal digit
// per cycle until its leading digit is found, the SIZE and PLACE states size
// the field, and then one character is produced per cycle while the receiver
// accepts, up to 64. A single 66-bit digit shifter, a digit counter and one
// position counter do all the work. s_axis_tready is high only while no item
// is in progress.
// When the receiver stalls, the current character holds in the output
// register and the sequencer waits. Reset clears all configuration
// registers to zero and returns the block to idle with no output pending.
module octal_field_formatter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [off_pkg::VALUE_W-1:0]    s_axis_tdata,  // [63:0] value
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [off_pkg::CHAR_W-1:0]     m_axis_tdata,  // [7:0] char_out
	output logic                           m_axis_tlast,  // last_char
	output logic                           m_axis_tuser,  // [0] flag_error
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [off_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [off_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import off_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_SIZE  = 3'd2;
	localparam logic [2:0] ST_PLACE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]         state_q;
	logic               alt_form_q, left_justify_q, zero_pad_q, bad_flags_q;
	logic [LEN_W-1:0]   min_digits_q, field_width_q;
	logic [SHIFT_W-1:0] digits_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [LEN_W-1:0]   lz_q, len_q, lp_q, last_q, pos_q;
	logic               err_q;
	logic               out_valid_q, out_last_q, out_err_q;
	logic [CHAR_W-1:0]  out_char_q;

	logic [2:0]         top_digit;
	logic [LEN_W-1:0]   prec_sat, width_sat, dc_ext, lz_c, pad_c, rel_pos;
	logic [CHAR_W-1:0]  char_c;
	logic               take_digit, advance;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	assign top_digit = digits_q[SHIFT_W-1 -: 3];
	assign prec_sat  = (min_digits_q > FIELD_MAX) ? FIELD_MAX : min_digits_q;
	assign width_sat = (field_width_q > FIELD_MAX) ? FIELD_MAX : field_width_q;
	assign dc_ext    = LEN_W'(dcnt_q);
	assign pad_c     = (width_sat > len_q) ? (width_sat - len_q) : '0;
	assign advance   = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign rel_pos   = pos_q - lp_q;

	always_comb begin
		if (prec_sat != '0) begin
			lz_c = (prec_sat > dc_ext) ? (prec_sat - dc_ext) : '0;
		end else begin
			lz_c = (alt_form_q && top_digit != 3'd0) ? LEN_W'(1) : '0;
		end
	end

	always_comb begin
		take_digit = 1'b0;
		if (pos_q < lp_q) begin
			char_c = zero_pad_q ? CH_ZERO : CH_SPACE;
		end else if (rel_pos < lz_q) begin
			char_c = CH_ZERO;
		end else if (rel_pos < len_q) begin
			char_c     = CH_ZERO | CHAR_W'(top_digit);
			take_digit = 1'b1;
		end else begin
			char_c = CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_form_q     <= 1'b0;
			left_justify_q <= 1'b0;
			zero_pad_q     <= 1'b0;
			bad_flags_q    <= 1'b0;
			min_digits_q   <= '0;
			field_width_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ALT_FORM:     alt_form_q     <= cfg_data[0];
				CFG_LEFT_JUSTIFY: left_justify_q <= cfg_data[0];
				CFG_ZERO_PAD:     zero_pad_q     <= cfg_data[0];
				CFG_MIN_DIGITS:   min_digits_q   <= cfg_data;
				CFG_FIELD_WIDTH:  field_width_q  <= cfg_data;
				CFG_BAD_FLAGS:    bad_flags_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			digits_q    <= '0;
			dcnt_q      <= '0;
			lz_q        <= '0;
			len_q       <= '0;
			lp_q        <= '0;
			last_q      <= '0;
			pos_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !advance) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						digits_q <= SHIFT_W'(s_axis_tdata);
						dcnt_q   <= DCNT_W'(MAX_DIGITS);
						state_q  <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (dcnt_q > DCNT_W'(1) && top_digit == 3'd0) begin
						digits_q <= digits_q << 3;
						dcnt_q   <= dcnt_q - DCNT_W'(1);
					end else begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					lz_q    <= lz_c;
					len_q   <= dc_ext + lz_c;
					err_q   <= bad_flags_q || (zero_pad_q && min_digits_q != '0);
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					lp_q    <= (zero_pad_q || !left_justify_q) ? pad_c : '0;
					last_q  <= len_q + pad_c - LEN_W'(1);
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						out_char_q  <= char_c;
						out_last_q  <= (pos_q == last_q);
						out_err_q   <= err_q;
						pos_q       <= pos_q + LEN_W'(1);
						if (take_digit) begin
							digits_q <= digits_q << 3;
						end
						if (pos_q == last_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
